// ===== src/svs_pkg.sv =====
// Package: operation codes, tag bytes and encoder result type for the scalar serializer.
package svs_pkg;

    localparam int OP_W = 3;
    localparam int VAL_W = 64;
    localparam int MAX_BYTES = 9;
    localparam int CNT_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_BOOL   = 3'd0,
        OP_INT32  = 3'd1,
        OP_INT64  = 3'd2,
        OP_DOUBLE = 3'd3,
        OP_DATE   = 3'd4,
        OP_NULL   = 3'd5
    } op_t;

    localparam logic [7:0] TAG_T = 8'h54;
    localparam logic [7:0] TAG_F = 8'h46;
    localparam logic [7:0] TAG_N = 8'h4e;
    localparam logic [7:0] TAG_DATE = 8'h64;
    localparam logic [7:0] TAG_INT = 8'h49;
    localparam logic [7:0] TAG_LONG = 8'h4c;
    localparam logic [7:0] TAG_LONG32 = 8'h59;
    localparam logic [7:0] TAG_DBL = 8'h44;
    localparam logic [7:0] TAG_DZERO = 8'h5b;
    localparam logic [7:0] TAG_DONE = 8'h5c;
    localparam logic [7:0] TAG_DBYTE = 8'h5d;
    localparam logic [7:0] TAG_DSHORT = 8'h5e;
    localparam logic [7:0] TAG_DFLOAT = 8'h5f;

    // Encoded item: bytes left-aligned, byte 0 is sent first.
    typedef struct packed {
        logic [MAX_BYTES*8-1:0] bytes;
        logic [CNT_W-1:0]       count;
    } enc_t;

endpackage

// ===== src/svs_encoder.sv =====
// Combinational encoder: one scalar to its compact byte string.
module svs_encoder (
    input  logic [svs_pkg::OP_W-1:0]  op,
    input  logic [svs_pkg::VAL_W-1:0] value,
    output svs_pkg::enc_t             enc
);
    import svs_pkg::*;

    localparam int BW = MAX_BYTES * 8;

    logic signed [63:0] sv;
    logic signed [31:0] iv32;
    logic        [10:0] ex;
    logic        [51:0] mant;
    logic        [52:0] full;
    logic               sgn;
    logic               dint;
    logic signed [16:0] dval;
    logic        [52:0] fmask;
    logic               is_flt;
    logic        [31:0] fbits;
    logic        [7:0]  t0;
    logic        [5:0]  k;

    // Pack n bytes left-aligned
    function automatic enc_t mk(input logic [BW-1:0] b, input int n);
        enc_t r;
        r.bytes = b;
        r.count = CNT_W'(n);
        return r;
    endfunction

    always_comb begin
        sv   = value;
        iv32 = value[31:0];
        sgn  = value[63];
        ex   = value[62:52];
        mant = value[51:0];
        full = {1'b1, mant};

        // Integral double with |v| < 2^15 (exponent 1023..1037), or zero.
        dint = 1'b0;
        dval = '0;
        fmask = '0;
        if (ex == 11'd0 && mant == '0) begin
            dint = 1'b1;
        end else if (ex >= 11'd1023 && ex <= 11'd1037) begin
            fmask = (53'd1 << (6'd52 - 6'(ex - 11'd1023))) - 53'd1;
            if ((full & fmask) == '0) begin
                dint = 1'b1;
                dval = 17'(full >> (6'd52 - 6'(ex - 11'd1023)));
                if (sgn) dval = -dval;
            end
        end
        // -0x8000 is integral and in short range too
        if (sgn && ex == 11'd1038 && mant == '0) begin
            dint = 1'b1;
            dval = -17'sd32768;
        end

        // Exact float test
        is_flt = 1'b0;
        fbits = '0;
        k = '0;
        if (ex == 11'h7ff) begin
            is_flt = (mant == '0);
            fbits = {sgn, 31'h7f800000};
        end else if (ex == 11'd0) begin
            is_flt = (mant == '0);
            fbits = {sgn, 31'd0};
        end else if (ex >= 11'd897 && ex <= 11'd1150) begin
            is_flt = (mant[28:0] == '0);
            fbits = {sgn, 8'(ex - 11'd896), mant[51:29]};
        end else if (ex >= 11'd874 && ex <= 11'd896) begin
            // subnormal float: k = -(E+97) = 926 - ex
            k = 6'(11'd926 - ex);
            is_flt = ((full & ((53'd1 << k) - 53'd1)) == '0);
            fbits = {sgn, 31'(full >> k)};
        end

        enc = mk('0, 0);
        t0 = '0;
        case (op)
            OP_BOOL:  enc = mk({value[0] ? TAG_T : TAG_F, 64'd0}, 1);
            OP_NULL:  enc = mk({TAG_N, 64'd0}, 1);
            OP_DATE:  enc = mk({TAG_DATE, value}, 9);
            OP_INT32: begin
                if (iv32 >= -32'sd16 && iv32 <= 32'sd47) begin
                    t0 = iv32[7:0] + 8'h90;
                    enc = mk({t0, 64'd0}, 1);
                end else if (iv32 >= -32'sd2048 && iv32 <= 32'sd2047) begin
                    t0 = 8'h c8 + {{5{iv32[31]}}, iv32[10:8]};
                    enc = mk({t0, iv32[7:0], 56'd0}, 2);
                end else if (iv32 >= -32'sd262144 && iv32 <= 32'sd262143) begin
                    t0 = 8'hd4 + {{5{iv32[31]}}, iv32[18:16]};
                    enc = mk({t0, iv32[15:0], 48'd0}, 3);
                end else begin
                    enc = mk({TAG_INT, iv32, 32'd0}, 5);
                end
            end
            OP_INT64: begin
                if (sv >= -64'sd8 && sv <= 64'sd15) begin
                    t0 = value[7:0] + 8'he0;
                    enc = mk({t0, 64'd0}, 1);
                end else if (sv >= -64'sd2048 && sv <= 64'sd2047) begin
                    t0 = 8'hf8 + {{5{sgn}}, value[10:8]};
                    enc = mk({t0, value[7:0], 56'd0}, 2);
                end else if (sv >= -64'sd262144 && sv <= 64'sd262143) begin
                    t0 = 8'h3c + {{5{sgn}}, value[18:16]};
                    enc = mk({t0, value[15:0], 48'd0}, 3);
                end else if (sv >= -64'sd2147483648 && sv <= 64'sd2147483647) begin
                    enc = mk({TAG_LONG32, value[31:0], 32'd0}, 5);
                end else begin
                    enc = mk({TAG_LONG, value}, 9);
                end
            end
            OP_DOUBLE: begin
                if (dint && dval == 17'sd0) begin
                    enc = mk({TAG_DZERO, 64'd0}, 1);
                end else if (dint && dval == 17'sd1) begin
                    enc = mk({TAG_DONE, 64'd0}, 1);
                end else if (dint && dval >= -17'sd128 && dval <= 17'sd127) begin
                    enc = mk({TAG_DBYTE, dval[7:0], 56'd0}, 2);
                end else if (dint) begin
                    enc = mk({TAG_DSHORT, dval[15:0], 48'd0}, 3);
                end else if (is_flt) begin
                    enc = mk({TAG_DFLOAT, fbits, 32'd0}, 5);
                end else begin
                    enc = mk({TAG_DBL, value}, 9);
                end
            end
            default: enc = mk('0, 0);
        endcase
    end

endmodule

// ===== src/scalar_value_serializer.sv =====
// Top level: compact scalar serializer, stream in, one byte per cycle out while m_axis_tready is high.
//
//  channel | ports     | dir | content
//  s_      | tdata 72b | in  | operation [2:0], value [66:3], zero fill
//  m_      | tdata 8b  | out | out_byte; tlast marks final byte of an item
//
//  Bytes: 1 to 9 per request with a used operation code.
//  A request is encoded in one pass into a staging register while the
//  previous item still drains from the shift register, so items run back to back.
//  Requests with unused operation codes produce nothing.
//  Reset (aresetn low, synchronous) empties both stages.
//  m_axis_tready low holds the current byte and tlast.
module scalar_value_serializer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // operation[2:0], value[66:3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
    output logic        m_axis_tlast
);
    import svs_pkg::*;

    enc_t stage_reg, stage_next;
    logic stage_vld_reg, stage_vld_next;
    enc_t enc;

    logic [MAX_BYTES*8-1:0] sh_reg, sh_next;
    logic [CNT_W-1:0]       left_reg, left_next;

    logic s_fire, m_fire, load;

    svs_encoder u_enc (
        .op    (s_axis_tdata[2:0]),
        .value (s_axis_tdata[66:3]),
        .enc   (enc)
    );

    assign m_axis_tvalid = (left_reg != '0);
    assign m_axis_tdata  = sh_reg[MAX_BYTES*8-1 -: 8];
    assign m_axis_tlast  = (left_reg == CNT_W'(1));
    assign m_fire = m_axis_tvalid && m_axis_tready;
    // shifter free after this cycle
    assign load = !m_axis_tvalid || (m_fire && m_axis_tlast);
    assign s_axis_tready = !stage_vld_reg || load;
    assign s_fire = s_axis_tvalid && s_axis_tready;

    always_comb begin
        sh_next = sh_reg;
        left_next = left_reg;
        stage_next = stage_reg;
        stage_vld_next = stage_vld_reg;
        if (m_fire) begin
            sh_next = sh_reg << 8;
            left_next = left_reg - CNT_W'(1);
        end
        if (load && stage_vld_reg) begin
            sh_next = stage_reg.bytes;
            left_next = stage_reg.count;
            stage_vld_next = 1'b0;
        end
        if (s_fire) begin
            stage_next = enc;
            stage_vld_next = (enc.count != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg <= 1'b0;
            left_reg <= '0;
        end else begin
            stage_vld_reg <= stage_vld_next;
            left_reg <= left_next;
        end
        stage_reg <= stage_next;
        sh_reg <= sh_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= CNT_W'(MAX_BYTES)) else $error("byte count overflow");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled byte changed");
    a_stage_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_vld_reg |-> stage_reg.count != '0) else $error("empty item staged");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !stage_vld_reg |-> s_axis_tready) else $error("ready low with free stage");

endmodule
